### hw/rtl/c3ms_pkg.sv
// Shared constants and controller-to-datapath command types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package c3ms_pkg;
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int MaxInCh   = 16;
  localparam int MaxOutCh  = 16;
  localparam int Taps      = 3;
  localparam int WeightDepth = MaxOutCh * MaxInCh * Taps * Taps;
  localparam int LineDepth   = Taps * MaxWidth * MaxInCh;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_WEIGHT = 2'd1;
  localparam logic [1:0] OP_BIAS   = 2'd2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IN_CH  = 3'd1;
  localparam logic [2:0] REG_OUT_CH = 3'd2;
  localparam logic [2:0] REG_SHIFT  = 3'd3;
  localparam logic [2:0] REG_BIAS   = 3'd4;

  typedef struct packed {
    logic        line_we;
    logic [13:0] line_waddr;
    logic [15:0] sample;
    logic        w_we;
    logic [11:0] w_addr;
    logic [15:0] w_data;
    logic        b_we;
    logic [3:0]  b_idx;
    logic [31:0] b_data;
    logic        rd;
    logic        first;
    logic [13:0] line_raddr;
    logic        bias_add;
    logic        bias_en;
    logic        load_out;
    logic [4:0]  shift;
  } dp_cmd_t;

  typedef struct packed {
    logic [15:0] value;
    logic        saturated;
  } dp_status_t;
endpackage
`default_nettype wire

### hw/rtl/c3ms_if.sv
// Stream and configuration channel interfaces.
// Depends on nothing; used by the top level and its environment.
`timescale 1ns / 1ps
`default_nettype none
interface c3ms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        frame_start;
  logic signed [15:0] sample;
  logic [11:0] table_index;
  logic signed [15:0] weight_value;
  logic signed [31:0] bias_value;
  modport source (output valid, opcode, frame_start, sample, table_index,
                  weight_value, bias_value, input ready);
  modport sink (input valid, opcode, frame_start, sample, table_index,
                weight_value, bias_value, output ready);
endinterface

interface c3ms_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] out_value;
  logic [3:0]  out_filter;
  logic [7:0]  out_row;
  logic [7:0]  out_col;
  logic        saturated;
  logic        last;
  modport source (output valid, out_value, out_filter, out_row, out_col,
                  saturated, last, input ready);
  modport sink (input valid, out_value, out_filter, out_row, out_col,
                saturated, last, output ready);
endinterface

interface c3ms_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/c3ms_datapath.sv
// Datapath: line, weight and bias stores, MAC pipeline, bias, shift, saturate.
// Depends on c3ms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c3ms_datapath
  import c3ms_pkg::*;
(
  input  wire logic    clk,
  input  wire dp_cmd_t cmd,
  output dp_status_t   status
);
  logic signed [15:0] line_mem [LineDepth];
  logic signed [15:0] weight_mem [WeightDepth];
  logic signed [31:0] bias_r [MaxOutCh];
  logic signed [15:0] s_r, k_r;
  logic signed [31:0] prod_r;
  logic signed [47:0] acc_r, sum_r, shifted;
  logic               first1_r, first2_r, v1_r, v2_r;
  logic [3:0]         bsel_r;
  dp_status_t         stat_r;

  always_ff @(posedge clk) begin
    if (cmd.line_we) line_mem[cmd.line_waddr] <= cmd.sample;
    if (cmd.w_we) weight_mem[cmd.w_addr] <= cmd.w_data;
    if (cmd.b_we) bias_r[cmd.b_idx] <= cmd.b_data;
    s_r <= line_mem[cmd.line_raddr];
    k_r <= weight_mem[cmd.w_addr];
  end

  // Bias entry of the current filter comes in on b_idx while summing.
  always_ff @(posedge clk) begin
    v1_r     <= cmd.rd;
    first1_r <= cmd.first;
    v2_r     <= v1_r;
    first2_r <= first1_r;
    prod_r   <= s_r * k_r;
    if (v2_r) acc_r <= first2_r ? 48'(prod_r) : acc_r + 48'(prod_r);
    bsel_r <= cmd.b_idx;
    if (cmd.bias_add)
      sum_r <= cmd.bias_en ? acc_r + 48'(bias_r[bsel_r]) : acc_r;
    if (cmd.load_out) begin
      if (shifted > 48'sd32767) begin
        stat_r.value <= 16'h7FFF; stat_r.saturated <= 1'b1;
      end else if (shifted < -48'sd32768) begin
        stat_r.value <= 16'h8000; stat_r.saturated <= 1'b1;
      end else begin
        stat_r.value <= shifted[15:0]; stat_r.saturated <= 1'b0;
      end
    end
  end

  assign shifted = sum_r >>> cmd.shift;
  assign status  = stat_r;
endmodule
`default_nettype wire

### hw/rtl/c3ms_ctrl.sv
// Controller: config registers, pixel position, window sequencing FSM.
// Depends on c3ms_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module c3ms_ctrl
  import c3ms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic        in_frame_start,
  input  wire logic [15:0] in_sample,
  input  wire logic [11:0] in_table_index,
  input  wire logic [15:0] in_weight_value,
  input  wire logic [31:0] in_bias_value,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_filter,
  output logic [7:0]       out_row,
  output logic [7:0]       out_col,
  output logic             out_last,
  output dp_cmd_t          cmd
);
  typedef enum logic [2:0] {S_IDLE, S_MAC, S_W1, S_W2, S_BIAS, S_SHF, S_OUT} st_t;
  st_t st_r;
  logic [8:0] width_r;
  logic [4:0] ich_r, och_r, shift_r;
  logic       ben_r;
  logic [8:0] row_r;
  logic [7:0] col_r;
  logic [3:0] ch_r;
  logic [1:0] rm_r, top_r, dr_r, dc_r;
  logic [7:0] wrow_r, wcol_r;
  logic [3:0] f_r, ci_r;
  logic [11:0] waddr_r;
  logic [8:0] w_eff;
  logic [4:0] ic_eff, oc_eff;
  logic [8:0] r0;
  logic [7:0] c0;
  logic [3:0] ch0;
  logic [1:0] rm0, rsel;
  logic [2:0] rsum;
  logic       acc_in, is_smp;

  assign w_eff  = (width_r < 9'd3) ? 9'd3 :
                  ((width_r > 9'(MaxWidth)) ? 9'(MaxWidth) : width_r);
  assign ic_eff = (ich_r == 5'd0) ? 5'd1 : ((ich_r > 5'd16) ? 5'd16 : ich_r);
  assign oc_eff = (och_r == 5'd0) ? 5'd1 : ((och_r > 5'd16) ? 5'd16 : och_r);

  assign in_ready = (st_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign is_smp   = acc_in && (in_opcode == OP_SAMPLE);
  assign r0  = in_frame_start ? 9'd0 : row_r;
  assign c0  = in_frame_start ? 8'd0 : col_r;
  assign ch0 = in_frame_start ? 4'd0 : ch_r;
  assign rm0 = in_frame_start ? 2'd0 : rm_r;
  assign rsum = {1'b0, top_r} + {1'b0, dr_r};
  assign rsel = (rsum >= 3'd3) ? 2'(rsum - 3'd3) : rsum[1:0];

  assign out_valid  = (st_r == S_OUT);
  assign out_filter = f_r;
  assign out_row    = wrow_r;
  assign out_col    = wcol_r;
  assign out_last   = ({1'b0, f_r} + 5'd1 == oc_eff);

  always_comb begin
    cmd = '0;
    cmd.sample     = in_sample;
    cmd.line_waddr = {rm0, c0, ch0};
    cmd.line_we    = is_smp && (r0 < 9'(MaxHeight));
    cmd.w_we       = acc_in && (in_opcode == OP_WEIGHT)
                     && (in_table_index < 12'(WeightDepth));
    cmd.w_data     = in_weight_value;
    cmd.w_addr     = (st_r == S_MAC) ? waddr_r : in_table_index;
    cmd.b_we       = acc_in && (in_opcode == OP_BIAS) && (in_table_index[11:4] == 8'd0);
    cmd.b_idx      = cmd.b_we ? in_table_index[3:0] : f_r;
    cmd.b_data     = in_bias_value;
    cmd.rd         = (st_r == S_MAC);
    cmd.first      = (ci_r == 4'd0) && (dr_r == 2'd0) && (dc_r == 2'd0);
    cmd.line_raddr = {rsel, 8'(wcol_r + {6'd0, dc_r}), ci_r};
    cmd.bias_add   = (st_r == S_BIAS);
    cmd.bias_en    = ben_r;
    cmd.load_out   = (st_r == S_SHF);
    cmd.shift      = shift_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      width_r <= 9'd256; ich_r <= 5'd1; och_r <= 5'd1; shift_r <= 5'd0; ben_r <= 1'b0;
      row_r <= '0; col_r <= '0; ch_r <= '0; rm_r <= '0;
      f_r <= '0; ci_r <= '0; dr_r <= '0; dc_r <= '0; waddr_r <= '0;
      top_r <= '0; wrow_r <= '0; wcol_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r <= cfg_data;
          REG_IN_CH:  ich_r   <= cfg_data[4:0];
          REG_OUT_CH: och_r   <= cfg_data[4:0];
          REG_SHIFT:  shift_r <= cfg_data[4:0];
          REG_BIAS:   ben_r   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: begin
          if (is_smp) begin
            if (r0 < 9'(MaxHeight)) begin
              if ({1'b0, ch0} + 5'd1 < ic_eff) begin
                row_r <= r0; col_r <= c0; rm_r <= rm0;
                ch_r  <= ch0 + 4'd1;
              end else begin
                if (r0 >= 9'd2 && c0 >= 8'd2) begin
                  wrow_r <= 8'(r0 - 9'd2);
                  wcol_r <= c0 - 8'd2;
                  top_r  <= (rm0 == 2'd2) ? 2'd0 : rm0 + 2'd1;
                  f_r <= '0; ci_r <= '0; dr_r <= '0; dc_r <= '0; waddr_r <= '0;
                  st_r <= S_MAC;
                end
                ch_r <= '0;
                if ({1'b0, c0} + 9'd1 >= w_eff) begin
                  col_r <= '0;
                  row_r <= r0 + 9'd1;
                  rm_r  <= (rm0 == 2'd2) ? 2'd0 : rm0 + 2'd1;
                end else begin
                  col_r <= c0 + 8'd1;
                  row_r <= r0;
                  rm_r  <= rm0;
                end
              end
            end else begin
              // past the last row: drop the word, keep the position
              row_r <= r0; col_r <= c0; ch_r <= ch0; rm_r <= rm0;
            end
          end
        end
        S_MAC: begin
          waddr_r <= waddr_r + 12'd1;
          if (dc_r != 2'd2) begin
            dc_r <= dc_r + 2'd1;
          end else begin
            dc_r <= '0;
            if (dr_r != 2'd2) begin
              dr_r <= dr_r + 2'd1;
            end else begin
              dr_r <= '0;
              if ({1'b0, ci_r} + 5'd1 < ic_eff) begin
                ci_r <= ci_r + 4'd1;
              end else begin
                ci_r <= '0;
                st_r <= S_W1;
              end
            end
          end
        end
        S_W1:   st_r <= S_W2;
        S_W2:   st_r <= S_BIAS;
        S_BIAS: st_r <= S_SHF;
        S_SHF:  st_r <= S_OUT;
        S_OUT: begin
          if (out_ready) begin
            if (out_last) begin
              st_r <= S_IDLE;
            end else begin
              f_r  <= f_r + 4'd1;
              st_r <= S_MAC;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/conv3x3_multichannel_stream.sv
// Top level of the streaming 3x3 multichannel convolution.
// Depends on c3ms_pkg, c3ms_if, c3ms_ctrl and c3ms_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  - in_bus carries one word per item: a sample (opcode sample), a weight
//    write or a bias write. Load weights and bias before streaming samples.
//  - cfg_bus writes the five registers (width, in/out channels, shift,
//    bias enable); it is always ready. Write it only while the block is idle.
//  - out_bus gives one word per filter once a window completes, with last
//    on the final filter.
//  - Table writes and samples that close no window leave in_bus.ready high.
//  - A completing sample runs, for each filter, a pass over the 3x3 taps of
//    all C input channels, C being the clamped input channel count: one
//    multiply-accumulate per cycle on the shared MAC, reading one line-store
//    and one weight-store entry per cycle, then pipeline drain (S_W1, S_W2),
//    bias (S_BIAS) and shift with saturation (S_SHF); the result word then
//    waits in S_OUT until it is taken.
//  - in_bus.ready is low while a window is summed or a result waits; a
//    stalled receiver holds the result word and the block waits with it.
//  - Reset (rst_n low, synchronous) restores default registers and the
//    position to row 0, column 0, channel 0. Stores keep their contents;
//    read only entries that were written.
module conv3x3_multichannel_stream
  import c3ms_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  c3ms_in_if.sink   in_bus,
  c3ms_out_if.source out_bus,
  c3ms_cfg_if.sink  cfg_bus
);
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_bus.ready = 1'b1;

  // Sequence positions, windows and output handshake.
  c3ms_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_bus.valid),
    .in_ready        (in_bus.ready),
    .in_opcode       (in_bus.opcode),
    .in_frame_start  (in_bus.frame_start),
    .in_sample       (in_bus.sample),
    .in_table_index  (in_bus.table_index),
    .in_weight_value (in_bus.weight_value),
    .in_bias_value   (in_bus.bias_value),
    .cfg_valid       (cfg_bus.valid),
    .cfg_index       (cfg_bus.index),
    .cfg_data        (cfg_bus.data),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_filter      (out_bus.out_filter),
    .out_row         (out_bus.out_row),
    .out_col         (out_bus.out_col),
    .out_last        (out_bus.last),
    .cmd             (cmd)
  );

  // Hold stores and do the arithmetic.
  c3ms_datapath u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .status (status)
  );

  assign out_bus.out_value = status.value;
  assign out_bus.saturated = status.saturated;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !in_bus.ready)
    else $error("input taken while a result word waits");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready) |=> !out_bus.valid)
    else $error("result word repeated");

  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !cmd.line_we && !cmd.w_we)
    else $error("store written during summation");
endmodule
`default_nettype wire
